FILE: hdl/tgmb_pkg.sv
// shared types and constants for the tile grid mesh builder
package tgmb_pkg;

    // fixed field widths
    localparam int IDX_W  = 15;
    localparam int TILE_W = 6;
    localparam int POS_W  = 8;

    // points of the 3x3 tile grid and triangles per tile
    localparam int NUM_POINTS = 9;
    localparam int NUM_TRIS   = 8;
    localparam int PT_W       = $clog2(NUM_POINTS);
    localparam int TRI_W      = $clog2(NUM_TRIS);

    typedef logic [PT_W-1:0] t_pt;

    // grid point triples of the eight triangles, point index = row*3+col
    localparam t_pt TRI_POINTS [NUM_TRIS][3] = '{
        '{4'd3, 4'd4, 4'd0}, '{4'd4, 4'd1, 4'd0},
        '{4'd4, 4'd2, 4'd1}, '{4'd4, 4'd5, 4'd2},
        '{4'd6, 4'd4, 4'd3}, '{4'd6, 4'd7, 4'd4},
        '{4'd7, 4'd8, 4'd4}, '{4'd8, 4'd5, 4'd4}
    };

    // record kinds
    localparam logic KIND_VERTEX   = 1'b0;
    localparam logic KIND_TRIANGLE = 1'b1;

    // controls from the sequencer to the vertex store
    typedef struct packed {
        logic fwd_rd;
        logic rev_rd;
        logic wr;
    } t_store_ctl;

    // sequencer states
    typedef enum logic [5:0] {
        S_CLEAR   = 6'b000001,
        S_IDLE    = 6'b000010,
        S_RD_FWD  = 6'b000100,
        S_RD_REV  = 6'b001000,
        S_RESOLVE = 6'b010000,
        S_TRI     = 6'b100000
    } t_state;

endpackage

FILE: hdl/tgmb_vstore.sv
// vertex store: cell-to-index and index-to-cell memories with power-up clear sweep
module tgmb_vstore
    import tgmb_pkg::*;
#(
    parameter int CELLS  = 16641,
    parameter int CELL_W = 15
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_store_ctl        i_ctl,
    input  logic [CELL_W-1:0] i_cell,
    input  logic [IDX_W-1:0]  i_rev_idx,
    input  logic [IDX_W-1:0]  i_wr_idx,
    output logic [IDX_W-1:0]  o_fwd_q,
    output logic [CELL_W-1:0] o_rev_q,
    output logic              o_busy
);

    logic [IDX_W-1:0]  r_fwd_mem [CELLS];
    logic [CELL_W-1:0] r_rev_mem [CELLS];
    logic [IDX_W-1:0]  r_fwd_q;
    logic [CELL_W-1:0] r_rev_q;
    logic [CELL_W-1:0] r_clr;
    logic              r_busy;

    logic [CELL_W-1:0] fwd_wr_addr;
    logic [IDX_W-1:0]  fwd_wr_data;
    logic              fwd_we;

    // clear sweep owns the forward write port after reset
    always_comb begin
        fwd_wr_addr = r_busy ? r_clr : i_cell;
        fwd_wr_data = r_busy ? '0 : i_wr_idx;
        fwd_we      = r_busy || i_ctl.wr;
    end

    // clear sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_clr  <= '0;
        end else if (r_busy) begin
            if (r_clr == CELL_W'(CELLS - 1)) begin
                r_busy <= 1'b0;
            end
            r_clr <= r_clr + 1'b1;
        end
    end

    // cell to vertex index memory
    always_ff @(posedge i_clk) begin
        if (fwd_we) begin
            r_fwd_mem[fwd_wr_addr] <= fwd_wr_data;
        end
        if (i_ctl.fwd_rd) begin
            r_fwd_q <= r_fwd_mem[i_cell];
        end
    end

    // vertex index to cell memory, proves a forward entry belongs to this mesh
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr && !r_busy) begin
            r_rev_mem[CELL_W'(i_wr_idx)] <= i_cell;
        end
        if (i_ctl.rev_rd) begin
            r_rev_q <= r_rev_mem[CELL_W'(i_rev_idx)];
        end
    end

    assign o_fwd_q = r_fwd_q;
    assign o_rev_q = r_rev_q;
    assign o_busy  = r_busy;

endmodule

FILE: hdl/tile_grid_mesh_builder_top.sv
// top level of the tile grid mesh builder: point sequencer and output register
//
// Input channel: one word per map tile (i_tile_x, i_tile_y, i_first_tile) on
// i_in_valid / o_in_ready. Output channel: vertex and triangle records on
// o_out_valid / i_out_ready, one record per word.
// For each tile the nine grid points are looked up one after another; every
// point not seen before in the current mesh gets the next vertex index and
// leaves as a vertex record, then eight triangle records follow, the eighth
// with o_last set. i_first_tile starts a new mesh by zeroing the vertex count.
// Tiles off the map give no records.
// Each point passes a forward memory read, a check read of the reverse memory
// and a resolve and write back step, in that order, as both store memories
// have registered reads; the triangles follow, one record a cycle while the
// receiver keeps up. The next tile is taken only after the last triangle of
// the tile before; an off-map tile leaves the sequencer idle for the next one.
// After reset the forward memory is swept clean, one entry a cycle, over all
// (2*MAP_SIDE+1)^2 entries (16641 at the default); o_in_ready stays low then.
// When the receiver stalls, the pending record holds in the output register
// and the sequencer waits before producing the next record.
module tile_grid_mesh_builder_top
    import tgmb_pkg::*;
#(
    parameter int MAP_SIDE = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [TILE_W-1:0]       i_tile_x,
    input  logic [TILE_W-1:0]       i_tile_y,
    input  logic                    i_first_tile,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic                    o_kind,
    output logic [IDX_W-1:0]        o_vertex_index,
    output logic signed [POS_W-1:0] o_pos_x_half,
    output logic signed [POS_W-1:0] o_pos_z_half,
    output logic [POS_W-1:0]        o_tex_u_half,
    output logic [POS_W-1:0]        o_tex_v_half,
    output logic [IDX_W-1:0]        o_tri_a,
    output logic [IDX_W-1:0]        o_tri_b,
    output logic [IDX_W-1:0]        o_tri_c,
    output logic                    o_last
);

    localparam int GRID_SIDE = 2 * MAP_SIDE + 1;
    localparam int CELLS     = GRID_SIDE * GRID_SIDE;
    localparam int CELL_W    = $clog2(CELLS);
    localparam int SIDE_W    = $clog2(MAP_SIDE + 1);
    localparam int CMP_W     = (SIDE_W > TILE_W) ? SIDE_W : TILE_W;

    t_state             r_state, n_state;
    logic [TILE_W-1:0]  r_tx, r_ty;
    logic [1:0]         r_row, r_col;
    logic [PT_W-1:0]    r_pt;
    logic [TRI_W-1:0]   r_tri;
    logic [IDX_W-1:0]   r_count;
    logic [CELL_W-1:0]  r_cell;
    logic [IDX_W-1:0]   r_idx [NUM_POINTS];

    logic                    r_out_valid;
    logic                    r_kind;
    logic [IDX_W-1:0]        r_vertex_index;
    logic signed [POS_W-1:0] r_pos_x, r_pos_z;
    logic [POS_W-1:0]        r_tex_u, r_tex_v;
    logic [IDX_W-1:0]        r_tri_a, r_tri_b, r_tri_c;
    logic                    r_last;

    t_store_ctl         store_ctl;
    logic [CELL_W-1:0]  store_cell;
    logic [IDX_W-1:0]   fwd_q;
    logic [CELL_W-1:0]  rev_q;
    logic               store_busy;

    logic               in_acc;
    logic               off_map;
    logic               slot_free;
    logic [POS_W-1:0]   gx, gz;
    logic [CELL_W-1:0]  cell_calc;
    logic               hit;
    logic               emit_vertex;
    logic               emit_tri;
    logic               pt_done;

    // vertex store
    tgmb_vstore #(
        .CELLS  (CELLS),
        .CELL_W (CELL_W)
    ) u_vstore (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (store_ctl),
        .i_cell    (store_cell),
        .i_rev_idx (fwd_q),
        .i_wr_idx  (r_count),
        .o_fwd_q   (fwd_q),
        .o_rev_q   (rev_q),
        .o_busy    (store_busy)
    );

    // grid position of the current point, in half-tile units plus one
    always_comb begin
        gx        = {1'b0, r_tx, 1'b0} + {6'b0, r_col};
        gz        = {1'b0, r_ty, 1'b0} + {6'b0, r_row};
        cell_calc = CELL_W'(gz) * CELL_W'(GRID_SIDE) + CELL_W'(gx);
    end

    // handshake and lookup decisions
    always_comb begin
        in_acc      = i_in_valid && o_in_ready;
        off_map     = (CMP_W'(i_tile_x) >= CMP_W'(MAP_SIDE))
                   || (CMP_W'(i_tile_y) >= CMP_W'(MAP_SIDE));
        slot_free   = !r_out_valid || i_out_ready;
        // a stored index is live only if below the count and pointing back here
        hit         = (fwd_q < r_count) && (rev_q == r_cell);
        emit_vertex = (r_state == S_RESOLVE) && !hit && slot_free;
        emit_tri    = (r_state == S_TRI) && slot_free;
        pt_done     = (r_state == S_RESOLVE) && (hit || slot_free);
        store_cell  = (r_state == S_RD_FWD) ? cell_calc : r_cell;
        store_ctl.fwd_rd = (r_state == S_RD_FWD);
        store_ctl.rev_rd = (r_state == S_RD_REV);
        store_ctl.wr     = emit_vertex;
    end

    assign o_in_ready = (r_state == S_IDLE);

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (!store_busy) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_acc && !off_map) n_state = S_RD_FWD;
            end
            S_RD_FWD:  n_state = S_RD_REV;
            S_RD_REV:  n_state = S_RESOLVE;
            S_RESOLVE: begin
                if (pt_done) begin
                    n_state = (r_pt == PT_W'(NUM_POINTS - 1)) ? S_TRI : S_RD_FWD;
                end
            end
            S_TRI: begin
                if (emit_tri && r_tri == TRI_W'(NUM_TRIS - 1)) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc && i_first_tile) begin
                r_count <= '0;
            end else if (emit_vertex) begin
                r_count <= r_count + 1'b1;
            end
            if (emit_vertex || emit_tri) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // tile, point and triangle counters
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_tx  <= i_tile_x;
            r_ty  <= i_tile_y;
            r_row <= 2'd0;
            r_col <= 2'd0;
            r_pt  <= '0;
            r_tri <= '0;
        end
        if (r_state == S_RD_FWD) begin
            r_cell <= cell_calc;
        end
        if (pt_done) begin
            r_idx[r_pt] <= hit ? fwd_q : r_count;
            r_pt        <= r_pt + 1'b1;
            if (r_col == 2'd2) begin
                r_col <= 2'd0;
                r_row <= r_row + 2'd1;
            end else begin
                r_col <= r_col + 2'd1;
            end
        end
        if (emit_tri) begin
            r_tri <= r_tri + 1'b1;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (emit_vertex) begin
            r_kind         <= KIND_VERTEX;
            r_vertex_index <= r_count;
            r_pos_x        <= gx - 8'd1;
            r_pos_z        <= gz - 8'd1;
            r_tex_u        <= gx;
            r_tex_v        <= gz;
            r_tri_a        <= '0;
            r_tri_b        <= '0;
            r_tri_c        <= '0;
            r_last         <= 1'b0;
        end else if (emit_tri) begin
            r_kind         <= KIND_TRIANGLE;
            r_vertex_index <= '0;
            r_pos_x        <= '0;
            r_pos_z        <= '0;
            r_tex_u        <= '0;
            r_tex_v        <= '0;
            r_tri_a        <= r_idx[TRI_POINTS[r_tri][0]];
            r_tri_b        <= r_idx[TRI_POINTS[r_tri][1]];
            r_tri_c        <= r_idx[TRI_POINTS[r_tri][2]];
            r_last         <= (r_tri == TRI_W'(NUM_TRIS - 1));
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_kind;
    assign o_vertex_index = r_vertex_index;
    assign o_pos_x_half   = r_pos_x;
    assign o_pos_z_half   = r_pos_z;
    assign o_tex_u_half   = r_tex_u;
    assign o_tex_v_half   = r_tex_v;
    assign o_tri_a        = r_tri_a;
    assign o_tri_b        = r_tri_b;
    assign o_tri_c        = r_tri_c;
    assign o_last         = r_last;

endmodule
